// File: design/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// Depends on nothing; every macro expects a clock and an active-low reset name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/rsfc_pkg.sv
// Package of the reply frame checker: codes, constants and shared types.
// Depends on nothing; used by every module of the block.
`default_nettype none

package rsfc_pkg;

    typedef enum logic [1:0] {
        FUNC_BYTE  = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_START = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_CSUM    = 2'd1,
        ST_RESP    = 2'd2,
        ST_TIMEOUT = 2'd3
    } status_t;

    localparam logic [1:0] REG_ADDR = 2'd0;
    localparam logic [1:0] REG_CMD  = 2'd1;
    localparam logic [1:0] REG_IDLE = 2'd2;

    localparam int          ADDR_WIDTH    = 4;
    localparam int          CNT_WIDTH_DEF = 16;

    localparam logic [7:0]  ADDR_RESET = 8'd5;
    localparam logic [7:0]  CMD_RESET  = 8'd168;
    localparam logic [15:0] IDLE_RESET = 16'd101;

    localparam logic [8:0]  ADDR_POS      = 9'd1;
    localparam logic [8:0]  LEN_POS       = 9'd2;
    localparam logic [8:0]  CMD_POS       = 9'd4;
    localparam logic [8:0]  CSUM_OFFSET   = 9'd2;
    localparam logic [8:0]  FRAME_EXTRA   = 9'd3;
    localparam logic [8:0]  MIN_FRAME_LEN = 9'd6;

    typedef struct packed {
        logic [7:0]  expected_address;
        logic [7:0]  expected_command;
        logic [15:0] idle_limit;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [8:0]  byte_count;
        logic [15:0] checksum_errors;
        logic [15:0] timeout_errors;
        logic [15:0] response_errors;
        logic [15:0] total_errors;
    } result_t;

endpackage

`default_nettype wire

// File: design/rs485_response_frame_checker.sv
// Top level of the reply frame checker: registers, frame core and result register.
// Depends on rsfc_pkg, rsfc_regs, rsfc_core and rsfc_out_reg.
//
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | func, rx_byte
// result   | out_valid / out_ready| status, byte_count, four error counters
// config   | psel, penable, pready| pwrite, paddr, pwdata, prdata
//
// One beat is taken per cycle unless a held result stalls the input register; a beat that
// ends a frame or times it out is registered as a result in the result register. The single
// pass through the frame state between the input and result registers sets that rate.
// Reset clears the frame state, the error counters and the registers to defaults.
// A held result stalls the input register, which then holds one further beat.
`default_nettype none

module rs485_response_frame_checker #(
    parameter int COUNT_WIDTH = rsfc_pkg::CNT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rsfc_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       func,
    input  logic [7:0]                       rx_byte,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       status,
    output logic [8:0]                       byte_count,
    output logic [15:0]                      checksum_errors,
    output logic [15:0]                      timeout_errors,
    output logic [15:0]                      response_errors,
    output logic [15:0]                      total_errors
);
    import rsfc_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_res;
    logic    res_valid;
    logic    slot_free;

    rsfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsfc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .rx_byte   (rx_byte),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    rsfc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign status          = out_res.status;
    assign byte_count      = out_res.byte_count;
    assign checksum_errors = out_res.checksum_errors;
    assign timeout_errors  = out_res.timeout_errors;
    assign response_errors = out_res.response_errors;
    assign total_errors    = out_res.total_errors;

endmodule

`default_nettype wire

// File: design/rsfc_regs.sv
// Configuration registers of the reply frame checker behind an APB-style port.
// Depends on rsfc_pkg.
`default_nettype none

module rsfc_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rsfc_pkg::ADDR_WIDTH-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output rsfc_pkg::cfg_t                     cfg
);
    import rsfc_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ADDR: cfg_next.expected_address = pwdata[7:0];
                REG_CMD:  cfg_next.expected_command = pwdata[7:0];
                REG_IDLE: cfg_next.idle_limit       = pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ADDR: prdata = {24'd0, cfg_reg.expected_address};
            REG_CMD:  prdata = {24'd0, cfg_reg.expected_command};
            REG_IDLE: prdata = {16'd0, cfg_reg.idle_limit};
            default:  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_address <= ADDR_RESET;
            cfg_reg.expected_command <= CMD_RESET;
            cfg_reg.idle_limit       <= IDLE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rsfc_core.sv
// Input register, frame state and error counters of the reply frame checker.
// Depends on rsfc_pkg; feeds a result beat to rsfc_out_reg.
`default_nettype none

module rsfc_core #(
    parameter int COUNT_WIDTH = rsfc_pkg::CNT_WIDTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rsfc_pkg::cfg_t    cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        func,
    input  logic [7:0]        rx_byte,
    input  logic              slot_free,
    output logic              res_valid,
    output rsfc_pkg::result_t res
);
    import rsfc_pkg::*;

    typedef logic [COUNT_WIDTH-1:0] cnt_t;

    logic        in_valid_reg, in_valid_next;
    func_t       func_reg;
    logic [7:0]  rx_byte_reg;

    logic        armed_reg, armed_next;
    logic [8:0]  idx_reg, idx_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  xor_reg, xor_next;
    logic        csum_ok_reg, csum_ok_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [15:0] idle_reg, idle_next;
    cnt_t        csum_cnt_reg, csum_cnt_next;
    cnt_t        tmo_cnt_reg, tmo_cnt_next;
    cnt_t        resp_cnt_reg, resp_cnt_next;
    cnt_t        total_cnt_reg, total_cnt_next;

    logic        advance;
    logic [8:0]  csum_pos;
    logic [8:0]  frame_len;
    logic [8:0]  frame_need;
    logic        chk_ok;
    logic        hdr_ok;
    status_t     res_status;

    function automatic cnt_t sat_inc(input cnt_t v);
        cnt_t r;
        r = v;
        if (v != '1)
        begin
            r = v + cnt_t'(1);
        end
        return r;
    endfunction

    assign advance  = in_valid_reg && slot_free;
    assign in_ready = !in_valid_reg || slot_free;

    always_comb
    begin
        in_valid_next = in_ready ? in_valid : in_valid_reg;
    end

    always_comb
    begin
        armed_next     = armed_reg;
        idx_next       = idx_reg;
        len_next       = len_reg;
        xor_next       = xor_reg;
        csum_ok_next   = csum_ok_reg;
        hdr_ok_next    = hdr_ok_reg;
        idle_next      = idle_reg;
        csum_cnt_next  = csum_cnt_reg;
        tmo_cnt_next   = tmo_cnt_reg;
        resp_cnt_next  = resp_cnt_reg;
        total_cnt_next = total_cnt_reg;
        res_valid      = 1'b0;
        res_status     = ST_OK;
        csum_pos       = 9'd0;
        frame_len      = 9'd0;
        frame_need     = 9'd0;
        chk_ok         = 1'b0;
        hdr_ok         = 1'b0;

        if (advance)
        begin
            case (func_reg)
                FUNC_START:
                begin
                    armed_next   = 1'b1;
                    idx_next     = 9'd0;
                    len_next     = 8'd0;
                    xor_next     = 8'd0;
                    csum_ok_next = 1'b0;
                    hdr_ok_next  = 1'b1;
                    idle_next    = 16'd0;
                end
                FUNC_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (idle_reg >= cfg.idle_limit)
                        begin
                            tmo_cnt_next   = sat_inc(tmo_cnt_reg);
                            total_cnt_next = sat_inc(total_cnt_reg);
                            armed_next     = 1'b0;
                            res_valid      = 1'b1;
                            res_status     = ST_TIMEOUT;
                        end
                        else
                        begin
                            idle_next = idle_reg + 16'd1;
                        end
                    end
                end
                FUNC_BYTE:
                begin
                    if (armed_reg)
                    begin
                        idle_next = 16'd0;
                        if (idx_reg == LEN_POS)
                        begin
                            len_next = rx_byte_reg;
                        end
                        csum_pos = {1'b0, len_next} + CSUM_OFFSET;
                        chk_ok   = csum_ok_reg;
                        if (idx_reg == csum_pos)
                        begin
                            chk_ok = (xor_reg == rx_byte_reg);
                        end
                        else if (idx_reg < csum_pos)
                        begin
                            xor_next = xor_reg ^ rx_byte_reg;
                        end
                        csum_ok_next = chk_ok;
                        hdr_ok = hdr_ok_reg;
                        if (idx_reg == ADDR_POS && rx_byte_reg != cfg.expected_address)
                        begin
                            hdr_ok = 1'b0;
                        end
                        if (idx_reg == CMD_POS && rx_byte_reg != cfg.expected_command)
                        begin
                            hdr_ok = 1'b0;
                        end
                        hdr_ok_next = hdr_ok;
                        idx_next    = idx_reg + 9'd1;
                        frame_len   = {1'b0, len_next} + FRAME_EXTRA;
                        frame_need  = (frame_len < MIN_FRAME_LEN) ? MIN_FRAME_LEN : frame_len;
                        if (idx_next >= frame_need)
                        begin
                            armed_next = 1'b0;
                            res_valid  = 1'b1;
                            if (!chk_ok)
                            begin
                                res_status     = ST_CSUM;
                                csum_cnt_next  = sat_inc(csum_cnt_reg);
                                total_cnt_next = sat_inc(total_cnt_reg);
                            end
                            else if (!hdr_ok)
                            begin
                                res_status     = ST_RESP;
                                resp_cnt_next  = sat_inc(resp_cnt_reg);
                                total_cnt_next = sat_inc(total_cnt_reg);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res.status          = res_status;
        res.byte_count      = idx_next;
        res.checksum_errors = 16'(csum_cnt_next);
        res.timeout_errors  = 16'(tmo_cnt_next);
        res.response_errors = 16'(resp_cnt_next);
        res.total_errors    = 16'(total_cnt_next);
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            func_reg    <= func_t'(func);
            rx_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            armed_reg     <= 1'b0;
            idx_reg       <= 9'd0;
            len_reg       <= 8'd0;
            xor_reg       <= 8'd0;
            csum_ok_reg   <= 1'b0;
            hdr_ok_reg    <= 1'b1;
            idle_reg      <= 16'd0;
            csum_cnt_reg  <= '0;
            tmo_cnt_reg   <= '0;
            resp_cnt_reg  <= '0;
            total_cnt_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            armed_reg     <= armed_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            xor_reg       <= xor_next;
            csum_ok_reg   <= csum_ok_next;
            hdr_ok_reg    <= hdr_ok_next;
            idle_reg      <= idle_next;
            csum_cnt_reg  <= csum_cnt_next;
            tmo_cnt_reg   <= tmo_cnt_next;
            resp_cnt_reg  <= resp_cnt_next;
            total_cnt_reg <= total_cnt_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rsfc_out_reg.sv
// Result register of the reply frame checker, holding one beat until taken.
// Depends on rsfc_pkg; loaded from rsfc_core.
`default_nettype none

module rsfc_out_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              res_valid,
    input  rsfc_pkg::result_t res,
    output logic              slot_free,
    output logic              out_valid,
    input  logic              out_ready,
    output rsfc_pkg::result_t out_res
);
    import rsfc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t res_reg;

    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_comb
    begin
        out_valid_next = slot_free ? res_valid : out_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: design/rsfc_checker.sv
// Port-level checks of the reply frame checker, bound to its top level.
// Depends on rsfc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rsfc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [1:0]  status,
    input  logic [8:0]  byte_count,
    input  logic [15:0] checksum_errors,
    input  logic [15:0] response_errors,
    input  logic [15:0] total_errors
);
    import rsfc_pkg::*;

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(byte_count))
    `ASSERT_SAME(a_ok_len, clk, rst_n, out_valid && status == ST_OK, byte_count >= MIN_FRAME_LEN)
    `ASSERT_SAME(a_total_ge, clk, rst_n, out_valid, total_errors >= checksum_errors && total_errors >= response_errors)
    `ASSERT_SAME(a_csum_cnt, clk, rst_n, out_valid && status == ST_CSUM, checksum_errors != 16'd0)

endmodule

bind rs485_response_frame_checker rsfc_checker u_rsfc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .byte_count      (byte_count),
    .checksum_errors (checksum_errors),
    .response_errors (response_errors),
    .total_errors    (total_errors)
);

`default_nettype wire
